/* sv/tfd_pkg.sv */
package tfd_pkg;

  // frame layout constants
  localparam logic [7:0] TERM_BYTE      = 8'hA5;
  localparam int unsigned FRAME_OVERHEAD = 10;
  localparam int unsigned MAC_BYTES      = 6;
  localparam int unsigned MAC_W          = 48;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_LEN_MISMATCH = 2'd1,
    STATUS_OVERFLOW     = 2'd2
  } status_e;

  // one reported frame
  typedef struct packed {
    status_e            status;
    logic [MAC_W-1:0]   mac_addr;
    logic [7:0]         payload_len;
    logic [7:0]         rssi;
  } result_t;

endpackage

/* sv/tfd_frame_tracker.sv */
module tfd_frame_tracker import tfd_pkg::*; #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 2);
  localparam int unsigned CmpW = (CntW > 9) ? CntW : 9;

  logic [CntW-1:0]  count_q, count_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       prev_q, prev_d;
  logic [7:0]       prev2_q, prev2_d;

  logic [CntW-1:0]  n;
  logic [MAC_W-1:0] mac_new;
  logic [MAC_W-1:0] mac_aligned;
  logic [7:0]       len_new;
  logic             term_hit;
  logic             overflow;

  // per-byte frame update
  always_comb begin
    n       = count_q + CntW'(1);
    mac_new = mac_q;
    len_new = len_q;
    if (count_q < CntW'(MAC_BYTES)) begin
      mac_new = {mac_q[MAC_W-9:0], rx_byte_i};
    end else if (count_q == CntW'(MAC_BYTES)) begin
      len_new = rx_byte_i;
    end

    // left-justify a partially received mac
    if (count_q >= CntW'(MAC_BYTES - 1)) begin
      mac_aligned = mac_new;
    end else begin
      unique case (count_q[2:0])
        3'd0:    mac_aligned = {mac_new[7:0],  40'd0};
        3'd1:    mac_aligned = {mac_new[15:0], 32'd0};
        3'd2:    mac_aligned = {mac_new[23:0], 24'd0};
        3'd3:    mac_aligned = {mac_new[31:0], 16'd0};
        default: mac_aligned = {mac_new[39:0], 8'd0};
      endcase
    end

    term_hit = (count_q != '0) && (prev_q == TERM_BYTE) && (rx_byte_i == TERM_BYTE);
    overflow = (count_q >= CntW'(MAX_FRAME));

    res_valid_o      = term_hit || overflow;
    res_o.mac_addr    = mac_aligned;
    res_o.payload_len = len_new;
    if (term_hit) begin
      res_o.status = ((CmpW'(len_new) + CmpW'(FRAME_OVERHEAD)) == CmpW'(n)) ?
                     STATUS_OK : STATUS_LEN_MISMATCH;
      res_o.rssi   = (count_q >= CntW'(2)) ? prev2_q : 8'd0;
    end else begin
      res_o.status = STATUS_OVERFLOW;
      res_o.rssi   = 8'd0;
    end

    // next state: restart after any accepted report
    count_d = count_q;
    mac_d   = mac_q;
    len_d   = len_q;
    prev_d  = prev_q;
    prev2_d = prev2_q;
    if (accept_i) begin
      if (res_valid_o) begin
        count_d = '0;
        mac_d   = '0;
        len_d   = '0;
        prev_d  = '0;
        prev2_d = '0;
      end else begin
        count_d = n;
        mac_d   = mac_new;
        len_d   = len_new;
        prev_d  = rx_byte_i;
        prev2_d = prev_q;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mac_q   <= '0;
      len_q   <= '0;
      prev_q  <= '0;
      prev2_q <= '0;
    end else begin
      count_q <= count_d;
      mac_q   <= mac_d;
      len_q   <= len_d;
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
    end
  end

`ifndef SYNTHESIS
  // count stays within the frame limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(MAX_FRAME))
    else $error("frame count past limit");

  // a report restarts the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o |=> count_q == '0 && prev_q == '0)
    else $error("frame not restarted after report");

  // a plain byte advances the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !res_valid_o |=> count_q == $past(count_q) + CntW'(1))
    else $error("frame count did not advance");
`endif

endmodule

/* sv/terminated_frame_deframer_core.sv */
// a result appears in the cycle after the byte that ends its frame is accepted
// throughput: one byte per cycle while in_stall_o is low; the single-pass frame tracker sets this rate
// a waiting result does not block the next byte unless out_stall_i holds it
// reset (rst_ni low, asynchronous) empties the output register and restarts the frame
module terminated_frame_deframer_core import tfd_pkg::*; #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [47:0] mac_addr_o,
  output logic [7:0]  payload_len_o,
  output logic [7:0]  rssi_o
);

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t result_q;

  // stall only while a result is held
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  tfd_frame_tracker #(
    .MAX_FRAME (MAX_FRAME)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      result_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = result_q.status;
  assign mac_addr_o    = result_q.mac_addr;
  assign payload_len_o = result_q.payload_len;
  assign rssi_o        = result_q.rssi;

`ifndef SYNTHESIS
  // input is stalled only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output");

  // a taken result with nothing new leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !(accept && res_valid) |=> !out_valid_q)
    else $error("result repeated");

  // a held result never carries the unused status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_o != 2'd3)
    else $error("bad status code");
`endif

endmodule
